// File: hdl/acc_mach_pkg.sv
// Package for the accumulator machine execute block.
// Holds field widths, default sizes, opcode and status codes and the sequencer state type.
// No dependencies; compiled first.
package acc_mach_pkg;

    localparam int INSN_W         = 16;
    localparam int OPND_W         = 12;
    localparam int ACC_FIELD_W    = 16;
    localparam int PC_FIELD_W     = 12;
    localparam int STATUS_W       = 2;
    localparam int DATA_WIDTH_DEF = 16;
    localparam int ADDR_WIDTH_DEF = 12;

    localparam logic [INSN_W-1:0] HALT_WORD = 16'h0000;
    localparam logic [INSN_W-1:0] NEG_WORD  = 16'h0001;

    typedef enum logic [3:0] {
        OP_SYS = 4'h0,
        OP_LDI = 4'h1,
        OP_LD  = 4'h2,
        OP_LDN = 4'h3,
        OP_ST  = 4'h4,
        OP_STN = 4'h5,
        OP_JMP = 4'h6,
        OP_JZ  = 4'h7,
        OP_JP  = 4'h8,
        OP_JN  = 4'h9,
        OP_ADD = 4'hA
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_EXEC    = 2'd0,
        ST_HALTED  = 2'd1,
        ST_ILLEGAL = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2
    } t_state;

endpackage

// File: hdl/acc_mach_if.sv
// Handshake interfaces for the accumulator machine: instruction channel and result channel.
// Depends on acc_mach_pkg for the field widths.
interface acc_mach_ins_if;
    logic                                valid;
    logic                                ready;
    logic [acc_mach_pkg::INSN_W-1:0]     instruction_word;

    modport source (output valid, output instruction_word, input ready);
    modport sink   (input valid, input instruction_word, output ready);
endinterface

interface acc_mach_res_if;
    logic                                    valid;
    logic                                    ready;
    logic signed [acc_mach_pkg::ACC_FIELD_W-1:0] acc_value;
    logic [acc_mach_pkg::PC_FIELD_W-1:0]     next_pc;
    logic [acc_mach_pkg::STATUS_W-1:0]       status;

    modport source (output valid, output acc_value, output next_pc, output status, input ready);
    modport sink   (input valid, input acc_value, input next_pc, input status, output ready);
endinterface

// File: hdl/accumulator_machine_execute.sv
// Accumulator machine execute block: top level with data memory and sequencer.
// Depends on acc_mach_pkg and the interfaces in acc_mach_if.sv.
//
// Usage:
// Instructions arrive on i_ins as one 16-bit word per transaction; each one
// yields exactly one result transaction on o_res carrying the accumulator, the
// next program counter and a status (executed, halted, undefined word).
// A one-entry input buffer takes the next instruction while the current one
// executes, and an output register holds a finished result until the sink
// takes it, so the two sides are decoupled.
// How long an instruction occupies the sequencer is set by the single port
// of the data memory and its registered read data: register-only and jump
// instructions and direct stores finish in S_IDLE; direct loads, adds and
// indirect stores in S_RD1; indirect loads in S_RD2 (two dependent reads).
// The result appears in the output register in the cycle after the last state.
// After reset the sequencer sweeps all 2**ADDR_WIDTH words of the data memory
// (4096 by default) to zero, one word per cycle; no instruction is accepted
// during the sweep. Accumulator, program counter and halted flag reset to zero.
// When the sink stalls, the finished result is held, one more instruction
// waits in the input buffer, and then i_ins.ready drops.
module accumulator_machine_execute #(
    parameter int DATA_WIDTH = acc_mach_pkg::DATA_WIDTH_DEF,
    parameter int ADDR_WIDTH = acc_mach_pkg::ADDR_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    acc_mach_ins_if.sink   i_ins,
    acc_mach_res_if.source o_res
);
    import acc_mach_pkg::*;

    localparam int DEPTH = 1 << ADDR_WIDTH;

    // Data memory: single port, registered read data.
    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rdata;
    logic                  w_mem_we;
    logic [ADDR_WIDTH-1:0] w_mem_addr;
    logic [DATA_WIDTH-1:0] w_mem_wdata;

    // Architectural state and sequencer.
    t_state                r_state, n_state;
    logic [DATA_WIDTH-1:0] r_acc, n_acc;
    logic [ADDR_WIDTH-1:0] r_pc, n_pc;
    logic                  r_halted, n_halted;
    t_opcode               r_cur_op, n_cur_op;
    logic [ADDR_WIDTH-1:0] r_clr_addr, n_clr_addr;

    // Input buffer.
    logic                  r_ib_valid;
    logic [INSN_W-1:0]     r_ib_word;

    // Output register.
    logic                  r_out_valid;
    logic [ACC_FIELD_W-1:0] r_out_acc;
    logic [PC_FIELD_W-1:0] r_out_pc;
    t_status               r_out_status;

    logic                  w_take;
    logic                  w_in_acc;
    logic                  w_finish;
    t_status               w_fin_status;
    logic [ADDR_WIDTH-1:0] w_pc_inc;
    logic [ADDR_WIDTH-1:0] w_opnd_addr;
    logic [ADDR_WIDTH-1:0] w_ind_addr;
    logic [DATA_WIDTH-1:0] w_imm;
    logic [DATA_WIDTH+ADDR_WIDTH-1:0] w_rd_ext;
    logic [DATA_WIDTH+OPND_W-1:0]     w_imm_ext;
    logic [DATA_WIDTH+ACC_FIELD_W-1:0] w_acc_ext;
    logic [ADDR_WIDTH+PC_FIELD_W-1:0]  w_pc_ext;

    // The sequencer starts an instruction only when the output register is
    // free or drains this cycle; it alone fills that register, so every
    // later finish of the same instruction finds room.
    assign w_take   = (r_state == S_IDLE) && r_ib_valid && (!r_out_valid || o_res.ready);
    assign w_in_acc = i_ins.valid && i_ins.ready;
    assign i_ins.ready = (r_state != S_CLEAR) && (!r_ib_valid || w_take);

    assign w_pc_inc    = r_pc + 1'b1;
    assign w_opnd_addr = r_ib_word[ADDR_WIDTH-1:0];
    assign w_rd_ext    = {{ADDR_WIDTH{1'b0}}, r_rdata};
    assign w_ind_addr  = w_rd_ext[ADDR_WIDTH-1:0];
    assign w_imm_ext   = {{DATA_WIDTH{1'b0}}, r_ib_word[OPND_W-1:0]};
    assign w_imm       = w_imm_ext[DATA_WIDTH-1:0];

    always_comb begin
        n_state      = r_state;
        n_acc        = r_acc;
        n_pc         = r_pc;
        n_halted     = r_halted;
        n_cur_op     = r_cur_op;
        n_clr_addr   = r_clr_addr;
        w_finish     = 1'b0;
        w_fin_status = ST_EXEC;
        w_mem_we     = 1'b0;
        w_mem_addr   = r_clr_addr;
        w_mem_wdata  = '0;

        unique case (r_state)
            S_CLEAR: begin
                w_mem_we   = 1'b1;
                n_clr_addr = r_clr_addr + 1'b1;
                if (&r_clr_addr) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_take) begin
                    n_cur_op = t_opcode'(r_ib_word[INSN_W-1:OPND_W]);
                    w_finish = 1'b1;
                    n_pc     = w_pc_inc;
                    if (r_halted) begin
                        // Halted: every word is ignored until reset.
                        w_fin_status = ST_HALTED;
                        n_pc         = r_pc;
                    end else begin
                        case (t_opcode'(r_ib_word[INSN_W-1:OPND_W])) inside
                            OP_SYS: begin
                                if (r_ib_word == HALT_WORD) begin
                                    n_halted     = 1'b1;
                                    w_fin_status = ST_HALTED;
                                    n_pc         = r_pc;
                                end else if (r_ib_word == NEG_WORD) begin
                                    n_acc = '0 - r_acc;
                                end else begin
                                    w_fin_status = ST_ILLEGAL;
                                end
                            end
                            OP_LDI: n_acc = w_imm;
                            OP_LD, OP_LDN, OP_STN, OP_ADD: begin
                                w_finish   = 1'b0;
                                n_pc       = r_pc;
                                w_mem_addr = w_opnd_addr;
                                n_state    = S_RD1;
                            end
                            OP_ST: begin
                                w_mem_we    = 1'b1;
                                w_mem_addr  = w_opnd_addr;
                                w_mem_wdata = r_acc;
                            end
                            OP_JMP: n_pc = w_opnd_addr;
                            OP_JZ: begin
                                if (r_acc == '0) begin
                                    n_pc = w_opnd_addr;
                                end
                            end
                            OP_JP: begin
                                if ((r_acc != '0) && !r_acc[DATA_WIDTH-1]) begin
                                    n_pc = w_opnd_addr;
                                end
                            end
                            OP_JN: begin
                                if (r_acc[DATA_WIDTH-1]) begin
                                    n_pc = w_opnd_addr;
                                end
                            end
                            default: w_fin_status = ST_ILLEGAL;
                        endcase
                    end
                end
            end
            S_RD1: begin
                // First read data is the word at the operand address.
                case (r_cur_op)
                    OP_LD: begin
                        n_acc    = r_rdata;
                        w_finish = 1'b1;
                    end
                    OP_ADD: begin
                        n_acc    = r_acc + r_rdata;
                        w_finish = 1'b1;
                    end
                    OP_LDN: begin
                        w_mem_addr = w_ind_addr;
                        n_state    = S_RD2;
                    end
                    default: begin
                        // Indirect store writes through the pointer just read.
                        w_mem_we    = 1'b1;
                        w_mem_addr  = w_ind_addr;
                        w_mem_wdata = r_acc;
                        w_finish    = 1'b1;
                    end
                endcase
                if (w_finish) begin
                    n_pc    = w_pc_inc;
                    n_state = S_IDLE;
                end
            end
            S_RD2: begin
                n_acc    = r_rdata;
                w_finish = 1'b1;
                n_pc     = w_pc_inc;
                n_state  = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign w_acc_ext = {{ACC_FIELD_W{1'b0}}, n_acc};
    assign w_pc_ext  = {{PC_FIELD_W{1'b0}}, n_pc};

    // Memory: one access per cycle, read data registered.
    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_addr] <= w_mem_wdata;
        end
        r_rdata <= r_mem[w_mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_acc      <= '0;
            r_pc       <= '0;
            r_halted   <= 1'b0;
            r_cur_op   <= OP_SYS;
            r_clr_addr <= '0;
        end else begin
            r_state    <= n_state;
            r_acc      <= n_acc;
            r_pc       <= n_pc;
            r_halted   <= n_halted;
            r_cur_op   <= n_cur_op;
            r_clr_addr <= n_clr_addr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ib_valid <= 1'b0;
        end else begin
            r_ib_valid <= (r_ib_valid && !w_take) || w_in_acc;
        end
        if (w_in_acc) begin
            r_ib_word <= i_ins.instruction_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (w_finish) begin
            r_out_acc    <= w_acc_ext[ACC_FIELD_W-1:0];
            r_out_pc     <= w_pc_ext[PC_FIELD_W-1:0];
            r_out_status <= w_fin_status;
        end
    end

    assign o_res.valid     = r_out_valid;
    assign o_res.acc_value = $signed(r_out_acc);
    assign o_res.next_pc   = r_out_pc;
    assign o_res.status    = r_out_status;

    // The second read only follows the first one.
    a_rd2_after_rd1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD2) |-> ($past(r_state) == S_RD1))
        else $error("second read state entered out of order");

    // No result can exist while the memory is still being cleared.
    a_no_result_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!r_out_valid && !r_ib_valid))
        else $error("transaction present during memory clear");

    // Halt is sticky until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halted |=> r_halted)
        else $error("halted flag cleared without reset");

    // A finish never overwrites a result the sink has not taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_finish |-> (!r_out_valid || o_res.ready))
        else $error("result register overwritten while stalled");

endmodule
